// File: hdl/isl_pkg.sv
`timescale 1ns / 1ps

package isl_pkg;

  // default sizing of the list
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // fixed field widths of the item ports
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 5;
  localparam int STATUS_W = 2;

  // width of positions and counts carried to the cells (covers depth up to 256)
  localparam int CTL_W = 9;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_READ   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what each cell of the row does this cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_WRITE  = 2'd3
  } cell_mode_t;

  // command broadcast along the row of cells
  typedef struct packed {
    cell_mode_t       mode;
    logic [CTL_W-1:0] pos;
    logic [CTL_W-1:0] fill;
  } cell_ctl_t;

endpackage

// File: hdl/isl_cell.sv
`timescale 1ns / 1ps

module isl_cell #(
  parameter int IDX       = 0,
  parameter int WORD_BITS = isl_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  isl_pkg::cell_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  in_word,
  input  logic [WORD_BITS-1:0]  left_word,
  input  logic [WORD_BITS-1:0]  right_word,
  output logic [WORD_BITS-1:0]  word
);

  localparam logic [isl_pkg::CTL_W-1:0] ME = isl_pkg::CTL_W'(IDX);

  logic [WORD_BITS-1:0] word_next;

  // pick the new content from the broadcast command and this cell's place
  always_comb begin
    word_next = word;
    case (ctl.mode)
      isl_pkg::CM_INSERT: begin
        if (ME == ctl.pos) begin
          word_next = in_word;
        end else if ((ME > ctl.pos) && (ME <= ctl.fill)) begin
          word_next = left_word;
        end
      end
      isl_pkg::CM_REMOVE: begin
        if ((ME >= ctl.pos) && ((ME + isl_pkg::CTL_W'(1)) < ctl.fill)) begin
          word_next = right_word;
        end
      end
      isl_pkg::CM_WRITE: begin
        if (ME == ctl.pos) begin
          word_next = in_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // stored word, contents undefined until written
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// File: hdl/indexed_shift_list_core.sv
`timescale 1ns / 1ps
// result: registered when its item is accepted, valid in the next cycle
// throughput: one item per cycle while each result is taken; every cell of the
//   row shifts, loads or holds in the same cycle; one row update sets the rate
// reset: list length, insert run offset and output valid clear; cell words are
//   not reset and hold nothing meaningful until written

module indexed_shift_list_core #(
  parameter int DEPTH     = isl_pkg::DEPTH_DEF,
  parameter int WORD_BITS = isl_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [isl_pkg::KIND_W-1:0]    kind,
  input  logic [isl_pkg::INDEX_W-1:0]   index,
  input  logic [isl_pkg::VALUE_W-1:0]   value,
  input  logic                          run_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isl_pkg::VALUE_W-1:0]   read_value,
  output logic [isl_pkg::LENGTH_W-1:0]  length,
  output logic [isl_pkg::STATUS_W-1:0]  status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int POS_W = ((CNT_W > isl_pkg::INDEX_W) ? CNT_W : isl_pkg::INDEX_W) + 1;
  localparam int RX_W  = (IDX_W > isl_pkg::INDEX_W) ? IDX_W : isl_pkg::INDEX_W;
  localparam int XW    = (WORD_BITS > isl_pkg::VALUE_W) ? WORD_BITS : isl_pkg::VALUE_W;
  localparam int LX_W  = (CNT_W > isl_pkg::LENGTH_W) ? CNT_W : isl_pkg::LENGTH_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]     fill_count;
  logic [CNT_W-1:0]     fill_count_next;
  logic [CNT_W-1:0]     run_offset;
  logic [CNT_W-1:0]     run_offset_next;
  logic                 take;
  logic [POS_W-1:0]     index_p;
  logic [POS_W-1:0]     fill_p;
  logic [POS_W-1:0]     ins_pos;
  logic [XW-1:0]        value_x;
  logic [WORD_BITS-1:0] word_in;
  logic [RX_W-1:0]      rd_idx_x;
  logic [WORD_BITS-1:0] rd_word;
  logic [XW-1:0]        rd_x;
  logic [LX_W-1:0]      len_x;
  logic [isl_pkg::VALUE_W-1:0] rd_result;
  isl_pkg::status_t     st;
  isl_pkg::cell_mode_t  mode_sel;
  logic [POS_W-1:0]     pos_sel;
  isl_pkg::cell_ctl_t   ctl;
  logic [WORD_BITS-1:0] words [DEPTH];

  // handshake: the output register frees as its item is taken
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // width alignment of the incoming fields
  assign index_p  = POS_W'(index);
  assign fill_p   = POS_W'(fill_count);
  assign ins_pos  = index_p + POS_W'(run_offset);
  assign value_x  = XW'(value);
  assign word_in  = value_x[WORD_BITS-1:0];
  assign rd_idx_x = RX_W'(index);
  assign rd_word  = words[rd_idx_x[IDX_W-1:0]];
  assign rd_x     = XW'(rd_word);

  // decode the operation and check it against the current length
  always_comb begin
    st              = isl_pkg::ST_OK;
    mode_sel        = isl_pkg::CM_HOLD;
    pos_sel         = index_p;
    fill_count_next = fill_count;
    run_offset_next = '0;
    rd_result       = '0;
    case (kind)
      isl_pkg::KIND_APPEND: begin
        if (fill_count == FULL_CNT) begin
          st = isl_pkg::ST_FULL;
        end else begin
          mode_sel        = isl_pkg::CM_INSERT;
          pos_sel         = fill_p;
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      isl_pkg::KIND_INSERT: begin
        if (ins_pos > fill_p) begin
          st = isl_pkg::ST_RANGE;
        end else if (fill_count == FULL_CNT) begin
          st = isl_pkg::ST_FULL;
        end else begin
          mode_sel        = isl_pkg::CM_INSERT;
          pos_sel         = ins_pos;
          fill_count_next = fill_count + CNT_W'(1);
        end
        if (run_last) begin
          run_offset_next = '0;
        end else if (st == isl_pkg::ST_OK) begin
          run_offset_next = run_offset + CNT_W'(1);
        end else begin
          run_offset_next = run_offset;
        end
      end
      isl_pkg::KIND_REMOVE: begin
        if (index_p >= fill_p) begin
          st = isl_pkg::ST_RANGE;
        end else begin
          mode_sel        = isl_pkg::CM_REMOVE;
          fill_count_next = fill_count - CNT_W'(1);
        end
      end
      isl_pkg::KIND_WRITE: begin
        if (index_p >= fill_p) begin
          st = isl_pkg::ST_RANGE;
        end else begin
          mode_sel = isl_pkg::CM_WRITE;
        end
      end
      isl_pkg::KIND_READ: begin
        if (index_p >= fill_p) begin
          st = isl_pkg::ST_RANGE;
        end else begin
          rd_result = rd_x[isl_pkg::VALUE_W-1:0];
        end
      end
      isl_pkg::KIND_CLEAR: begin
        fill_count_next = '0;
      end
      default: begin
        st = isl_pkg::ST_OK;
      end
    endcase
  end

  // command to the row, idle unless an item is taken
  always_comb begin
    ctl.mode = take ? mode_sel : isl_pkg::CM_HOLD;
    ctl.pos  = isl_pkg::CTL_W'(pos_sel);
    ctl.fill = isl_pkg::CTL_W'(fill_count);
  end

  assign len_x = LX_W'(fill_count_next);

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    isl_cell #(
      .IDX       (i),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .in_word    (word_in),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i])
    );
  end

  // list length and insert run offset
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      run_offset <= '0;
    end else if (take) begin
      fill_count <= fill_count_next;
      run_offset <= run_offset_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      read_value <= rd_result;
      length     <= len_x[isl_pkg::LENGTH_W-1:0];
      status     <= st;
    end
  end

endmodule
